@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ rtl/htbl_pkg.sv @@
// ----------------------------------------------------------------------------
// htbl_pkg
// Shared types and constants of the hashed token bucket limiter.
// ----------------------------------------------------------------------------
package htbl_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int TOKEN_W = 16;

  // lowbias32-style mixing multipliers
  localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic               claimed;
    logic [KEY_W-1:0]   owner;
    logic [TIME_W-1:0]  stamp;
    logic [TOKEN_W-1:0] tokens;
  } slot_word_t;

endpackage

@@ rtl/hashed_token_bucket_limiter.sv @@
// ----------------------------------------------------------------------------
// hashed_token_bucket_limiter
// Per-key token bucket rate limiter held in a hashed, linearly probed table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start with client_key and now_seconds; a request is
//   taken when start is high and busy is low. Each request gives exactly one
//   answer on allowed, marked by result_valid for one cycle. The receiver
//   cannot stall; the answer must be taken in that cycle.
//   rate_cap is written through cfg_valid/cfg_ready/cfg_data; the user must
//   write it only while the block is idle, which the block itself does not
//   enforce. cfg_ready is always high. With rate_cap at zero the answer
//   (allowed) follows in the cycle after the transfer. Otherwise the key is
//   hashed (mix, two multiplies and a fold, then a restoring remainder for a
//   non-power-of-two table) and up to PROBE_LIMIT slots are probed in the
//   slot memory, which has one write and one registered read port; the next
//   request may be taken in the cycle the answer is shown.
//   After reset the block sweeps the slot memory to clear its claimed marks,
//   one slot per cycle; busy is high meanwhile and configuration writes are
//   still taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hashed_token_bucket_limiter #(
  parameter int TABLE_DEPTH = 4096,
  parameter int PROBE_LIMIT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [htbl_pkg::KEY_W-1:0]     client_key,
  input  logic [htbl_pkg::TIME_W-1:0]    now_seconds,
  output logic                           result_valid,
  output logic                           allowed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htbl_pkg::TOKEN_W-1:0]   cfg_data
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE
  } ctrl_state_t;

  ctrl_state_t                    state;
  logic [htbl_pkg::TOKEN_W-1:0]   rate_cap;
  logic [htbl_pkg::KEY_W-1:0]     key_q;
  logic [htbl_pkg::TIME_W-1:0]    now_q;
  logic [AddrW-1:0]               clr_idx;
  logic [AddrW-1:0]               cur_idx;
  logic [AddrW-1:0]               base_idx;
  logic [AddrW-1:0]               next_idx;
  logic [CntW-1:0]                probe_cnt;
  htbl_pkg::slot_word_t           base_word;

  // slot memory and its ports
  htbl_pkg::slot_word_t           slot_mem [TABLE_DEPTH];
  htbl_pkg::slot_word_t           mem_rdata;
  htbl_pkg::slot_word_t           mem_wdata;
  logic                           mem_re;
  logic                           mem_we;
  logic [AddrW-1:0]               mem_raddr;
  logic [AddrW-1:0]               mem_waddr;

  logic                           hash_go;
  logic                           hash_done;
  logic [AddrW-1:0]               hash_base;

  // probe decision and token spend
  logic                           last_probe;
  logic                           owner_hit;
  htbl_pkg::slot_word_t           spend_src;
  htbl_pkg::slot_word_t           spend_word;
  htbl_pkg::slot_word_t           claim_word;
  logic [htbl_pkg::TOKEN_W-1:0]   refill_tokens;
  logic                           spend_ok;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_cap <= '0;
    end else if (cfg_valid && cfg_ready) begin
      rate_cap <= cfg_data;
    end
  end

  htbl_hash #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .go   (hash_go),
    .key  (client_key),
    .done (hash_done),
    .base (hash_base)
  );

  assign hash_go = (state == ST_IDLE) && start && (rate_cap != '0);

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= slot_mem[mem_raddr];
    end
  end

  assign next_idx   = (cur_idx == AddrW'(TABLE_DEPTH - 1)) ? '0 : cur_idx + 1'b1;
  assign last_probe = (probe_cnt == CntW'(PROBE_LIMIT - 1));
  assign owner_hit  = (mem_rdata.owner == key_q);

  // on an all-foreign probe run, spend from the base slot as first read
  always_comb begin
    if (owner_hit) begin
      spend_src = mem_rdata;
    end else if (probe_cnt == '0) begin
      spend_src = mem_rdata;
    end else begin
      spend_src = base_word;
    end
  end

  // refill on any forward step of time, then take one token if there is one
  always_comb begin
    spend_word    = spend_src;
    refill_tokens = spend_src.tokens;
    if (now_q > spend_src.stamp) begin
      refill_tokens    = rate_cap;
      spend_word.stamp = now_q;
    end
    spend_ok          = (refill_tokens != '0);
    spend_word.tokens = spend_ok ? refill_tokens - 1'b1 : refill_tokens;
  end

  always_comb begin
    claim_word.claimed = 1'b1;
    claim_word.owner   = key_q;
    claim_word.stamp   = now_q;
    claim_word.tokens  = rate_cap - 1'b1;
  end

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = next_idx;
    mem_we    = 1'b0;
    mem_waddr = cur_idx;
    mem_wdata = spend_word;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_IDLE: begin
      end
      ST_HASH: begin
        if (hash_done) begin
          mem_re    = 1'b1;
          mem_raddr = hash_base;
        end
      end
      ST_PROBE: begin
        if (!mem_rdata.claimed) begin
          mem_we    = 1'b1;
          mem_wdata = claim_word;
        end else if (owner_hit) begin
          mem_we = 1'b1;
        end else if (last_probe) begin
          mem_we    = 1'b1;
          mem_waddr = base_idx;
        end else begin
          mem_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AddrW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            key_q <= client_key;
            now_q <= now_seconds;
            if (rate_cap == '0) begin
              result_valid <= 1'b1;
              allowed      <= 1'b1;
            end else begin
              state <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            cur_idx   <= hash_base;
            base_idx  <= hash_base;
            probe_cnt <= '0;
            state     <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (probe_cnt == '0) begin
            base_word <= mem_rdata;
          end
          if (!mem_rdata.claimed) begin
            result_valid <= 1'b1;
            allowed      <= 1'b1;
            state        <= ST_IDLE;
          end else if (owner_hit || last_probe) begin
            result_valid <= 1'b1;
            allowed      <= spend_ok;
            state        <= ST_IDLE;
          end else begin
            cur_idx   <= next_idx;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // checks
  `ASSERT_PROP(a_write_phase, clk, rst, mem_we |-> (state == ST_CLEAR || state == ST_PROBE))
  `ASSERT_PROP(a_result_src, clk, rst,
    result_valid |-> $past(state == ST_PROBE || (start && !busy && rate_cap == '0)))
  `ASSERT_PROP(a_probe_write_ends, clk, rst, (state == ST_PROBE && mem_we) |=> result_valid)
  `ASSERT_PROP(a_hash_done_wait, clk, rst, hash_done |-> state == ST_HASH)
  `ASSERT_NEVER(a_probe_bound, clk, rst,
    state == ST_PROBE && probe_cnt > CntW'(PROBE_LIMIT - 1))

endmodule

@@ rtl/htbl_hash.sv @@
// ----------------------------------------------------------------------------
// htbl_hash
// Multi-cycle key hash: lowbias32-style mix, then reduction to a table slot.
// ----------------------------------------------------------------------------
module htbl_hash #(
  parameter int  TABLE_DEPTH = 4096,
  localparam int AddrW       = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [htbl_pkg::KEY_W-1:0]   key,
  output logic                         done,
  output logic [AddrW-1:0]             base
);

  localparam bit                IsPow2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int                RemBits  = 4;
  localparam int                RemSteps = 32 / RemBits;
  localparam int                StepW    = $clog2(RemSteps);
  localparam logic [AddrW:0]    Divisor  = (AddrW + 1)'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    H_IDLE, H_MUL_A, H_MUL_B, H_FOLD, H_REM
  } hash_state_t;

  hash_state_t      state;
  logic [31:0]      mix;
  logic [31:0]      mul_b_in;
  logic [31:0]      fold;
  logic [31:0]      quot;
  logic [31:0]      quot_next;
  logic [AddrW-1:0] rem;
  logic [AddrW-1:0] rem_next;
  logic [AddrW:0]   trial;
  logic [StepW-1:0] step;

  // xor-shift steps between and after the multiplies
  assign mul_b_in = mix ^ (mix >> 15);
  assign fold     = mix ^ (mix >> 16);

  // restoring remainder, RemBits bits per cycle
  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    trial     = '0;
    for (int j = 0; j < RemBits; j++) begin
      trial = {rem_next, quot_next[31]};
      if (trial >= Divisor) begin
        trial = trial - Divisor;
      end
      rem_next  = trial[AddrW-1:0];
      quot_next = {quot_next[30:0], 1'b0};
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (go) begin
            mix   <= key ^ (key >> 16);
            state <= H_MUL_A;
          end
        end
        H_MUL_A: begin
          mix   <= mix * htbl_pkg::MIX_MUL_A;
          state <= H_MUL_B;
        end
        H_MUL_B: begin
          mix   <= mul_b_in * htbl_pkg::MIX_MUL_B;
          state <= H_FOLD;
        end
        H_FOLD: begin
          if (IsPow2) begin
            base  <= fold[AddrW-1:0];
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            rem   <= '0;
            quot  <= fold;
            step  <= '0;
            state <= H_REM;
          end
        end
        H_REM: begin
          rem  <= rem_next;
          quot <= quot_next;
          step <= step + 1'b1;
          if (step == StepW'(RemSteps - 1)) begin
            base  <= rem_next;
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule
